### rtl/core/tasp_pkg.sv
// Shared widths, codes and reset values for the three-axis slew positioner.
package tasp_pkg;

   localparam int ANGLE_BITS   = 20;
   localparam int STEP_BITS    = ANGLE_BITS - 1;
   localparam int CMD_BITS     = 3;
   localparam int MASK_BITS    = 3;
   localparam int STATUS_BITS  = 3;
   localparam int CSR_IDX_BITS = 3;
   localparam int NUM_AXES     = 3;

   typedef logic signed [ANGLE_BITS-1:0] angle_type;
   typedef logic [STEP_BITS-1:0]         step_type;
   typedef logic [CMD_BITS-1:0]          cmd_type;
   typedef logic [MASK_BITS-1:0]         mask_type;
   typedef logic [STATUS_BITS-1:0]       status_type;
   typedef logic [CSR_IDX_BITS-1:0]      csr_idx_type;

   // commands
   localparam cmd_type CMD_TICK       = 3'd0;
   localparam cmd_type CMD_SET_TARGET = 3'd1;
   localparam cmd_type CMD_START      = 3'd2;
   localparam cmd_type CMD_STOP       = 3'd3;
   localparam cmd_type CMD_HOME       = 3'd4;

   // result status
   localparam status_type ST_OK          = 3'd0;
   localparam status_type ST_NOT_RUNNING = 3'd1;
   localparam status_type ST_OUT_OF_RANGE = 3'd2;
   localparam status_type ST_ALREADY_RUN = 3'd3;
   localparam status_type ST_ALREADY_STOP = 3'd4;

   // register indexes
   localparam csr_idx_type REG_AZ_MIN     = 3'd0;
   localparam csr_idx_type REG_AZ_MAX     = 3'd1;
   localparam csr_idx_type REG_EL_MIN     = 3'd2;
   localparam csr_idx_type REG_EL_MAX     = 3'd3;
   localparam csr_idx_type REG_POL_MIN    = 3'd4;
   localparam csr_idx_type REG_POL_MAX    = 3'd5;
   localparam csr_idx_type REG_STEP_LIMIT = 3'd6;

   // register reset values
   localparam angle_type AZ_MIN_RST  = angle_type'(0);
   localparam angle_type AZ_MAX_RST  = angle_type'(360000);
   localparam angle_type EL_MIN_RST  = angle_type'(-90000);
   localparam angle_type EL_MAX_RST  = angle_type'(90000);
   localparam angle_type POL_MIN_RST = angle_type'(-180000);
   localparam angle_type POL_MAX_RST = angle_type'(180000);
   localparam step_type  STEP_RST    = step_type'(500);

endpackage

### rtl/core/tasp_ifs.sv
// Channel interfaces: command beats, result beats and register writes.
interface tasp_req_if;
   logic                 valid;
   logic                 ready;
   tasp_pkg::cmd_type    command;
   tasp_pkg::mask_type   axis_mask;
   tasp_pkg::angle_type  az_value;
   tasp_pkg::angle_type  el_value;
   tasp_pkg::angle_type  pol_value;

   modport source (output valid, command, axis_mask, az_value, el_value, pol_value,
                   input ready);
   modport sink   (input valid, command, axis_mask, az_value, el_value, pol_value,
                   output ready);
endinterface

interface tasp_rsp_if;
   logic                   valid;
   logic                   ready;
   tasp_pkg::status_type   status;
   tasp_pkg::mask_type     axis_error;
   tasp_pkg::angle_type    az_position;
   tasp_pkg::angle_type    el_position;
   tasp_pkg::angle_type    pol_position;
   logic                   moving;
   logic                   running;
   logic                   calibrated;
   logic                   arrived;

   modport source (output valid, status, axis_error, az_position, el_position,
                   pol_position, moving, running, calibrated, arrived,
                   input ready);
   modport sink   (input valid, status, axis_error, az_position, el_position,
                   pol_position, moving, running, calibrated, arrived,
                   output ready);
endinterface

interface tasp_csr_if;
   logic                   valid;
   logic                   ready;
   tasp_pkg::csr_idx_type  index;
   tasp_pkg::angle_type    data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/three_axis_slew_positioner_unit.sv
// Three-axis slew positioner: limit registers, motion state and one-pass command logic.
// A command waits in the input register, then its result beat in the result register.
// Throughput: one command per cycle unless the result side stalls; these two registers
// form a two-stage pipe, and motion state updates as the item leaves the input stage.
// Reset (synchronous, active high): positions, targets and flags clear to zero,
// limits and step limit return to their defaults, both pipe stages empty.
module three_axis_slew_positioner_unit (
   input  logic        clock,
   input  logic        reset,
   tasp_req_if.sink    req_bus,
   tasp_rsp_if.source  rsp_bus,
   tasp_csr_if.sink    csr_bus
);

   localparam int WIDE_BITS = tasp_pkg::ANGLE_BITS + 2;
   typedef logic signed [WIDE_BITS-1:0] wide_type;

   function automatic wide_type clamp_w(wide_type v, wide_type lo, wide_type hi);
      wide_type r;
      r = (v < hi) ? v : hi;
      return (r > lo) ? r : lo;
   endfunction

   // limits
   tasp_pkg::angle_type lo_ff [tasp_pkg::NUM_AXES];
   tasp_pkg::angle_type hi_ff [tasp_pkg::NUM_AXES];
   tasp_pkg::step_type  step_ff;

   // motion state
   tasp_pkg::angle_type now_ff  [tasp_pkg::NUM_AXES];
   tasp_pkg::angle_type goal_ff [tasp_pkg::NUM_AXES];
   tasp_pkg::angle_type now_in  [tasp_pkg::NUM_AXES];
   tasp_pkg::angle_type goal_in [tasp_pkg::NUM_AXES];
   logic moving_ff, moving_in;
   logic running_ff, running_in;
   logic calib_ff, calib_in;

   // input stage
   logic                in_valid_ff;
   tasp_pkg::cmd_type   cmd_ff;
   tasp_pkg::mask_type  mask_ff;
   tasp_pkg::angle_type val_ff [tasp_pkg::NUM_AXES];

   // result stage
   logic                   out_valid_ff;
   tasp_pkg::status_type   status_ff, status_in;
   tasp_pkg::mask_type     axerr_ff, axerr_in;
   tasp_pkg::angle_type    pos_ff [tasp_pkg::NUM_AXES];
   logic                   moving_out_ff, running_out_ff, calib_out_ff;
   logic                   arrived_ff, arrived_in;

   // per-axis helpers
   tasp_pkg::angle_type tick_pos [tasp_pkg::NUM_AXES];
   tasp_pkg::angle_type home_pos [tasp_pkg::NUM_AXES];
   logic [tasp_pkg::NUM_AXES-1:0] near;
   logic [tasp_pkg::NUM_AXES-1:0] in_range;

   logic advance;
   logic req_take;
   logic csr_take;

   assign advance  = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;
   assign req_take = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;
   assign csr_take = csr_bus.valid;

   always_comb begin
      wide_type d, s, stp, sum, lo_w, hi_w;
      for (int i = 0; i < tasp_pkg::NUM_AXES; i++) begin
         lo_w = wide_type'(lo_ff[i]);
         hi_w = wide_type'(hi_ff[i]);
         stp  = {{(WIDE_BITS - tasp_pkg::STEP_BITS){1'b0}}, step_ff};
         d    = wide_type'(goal_ff[i]) - wide_type'(now_ff[i]);
         if (d > stp) begin
            s = stp;
         end else if (d < -stp) begin
            s = -stp;
         end else begin
            s = d;
         end
         sum  = wide_type'(now_ff[i]) + s;
         near[i] = (d >= wide_type'(-1)) && (d <= wide_type'(1));
         tick_pos[i] = near[i] ? goal_ff[i]
                               : tasp_pkg::angle_type'(clamp_w(sum, lo_w, hi_w));
         home_pos[i] = tasp_pkg::angle_type'(clamp_w(wide_type'(val_ff[i]), lo_w, hi_w));
         in_range[i] = (val_ff[i] >= lo_ff[i]) && (val_ff[i] <= hi_ff[i]);
      end
   end

   always_comb begin
      now_in     = now_ff;
      goal_in    = goal_ff;
      moving_in  = moving_ff;
      running_in = running_ff;
      calib_in   = calib_ff;
      status_in  = tasp_pkg::ST_OK;
      axerr_in   = '0;
      arrived_in = 1'b0;
      case (cmd_ff)
         tasp_pkg::CMD_TICK: begin
            if (moving_ff && running_ff) begin
               now_in = tick_pos;
               if (&near) begin
                  moving_in  = 1'b0;
                  arrived_in = 1'b1;
               end
            end
         end
         tasp_pkg::CMD_SET_TARGET: begin
            if (!running_ff) begin
               status_in = tasp_pkg::ST_NOT_RUNNING;
            end else begin
               for (int i = 0; i < tasp_pkg::NUM_AXES; i++) begin
                  if (mask_ff[i]) begin
                     if (in_range[i]) begin
                        goal_in[i] = val_ff[i];
                        moving_in  = 1'b1;
                     end else begin
                        axerr_in[i] = 1'b1;
                     end
                  end
               end
               if (axerr_in != '0) begin
                  status_in = tasp_pkg::ST_OUT_OF_RANGE;
               end
            end
         end
         tasp_pkg::CMD_START: begin
            if (running_ff) begin
               status_in = tasp_pkg::ST_ALREADY_RUN;
            end else begin
               running_in = 1'b1;
            end
         end
         tasp_pkg::CMD_STOP: begin
            if (running_ff) begin
               running_in = 1'b0;
               arrived_in = moving_ff;
               moving_in  = 1'b0;
            end else begin
               status_in = tasp_pkg::ST_ALREADY_STOP;
            end
         end
         tasp_pkg::CMD_HOME: begin
            now_in    = home_pos;
            goal_in   = home_pos;
            moving_in = 1'b0;
            calib_in  = 1'b1;
         end
         default: begin
            // unused codes leave everything as is
         end
      endcase
   end

   // limit registers
   always_ff @(posedge clock) begin
      if (reset) begin
         lo_ff[0] <= tasp_pkg::AZ_MIN_RST;
         hi_ff[0] <= tasp_pkg::AZ_MAX_RST;
         lo_ff[1] <= tasp_pkg::EL_MIN_RST;
         hi_ff[1] <= tasp_pkg::EL_MAX_RST;
         lo_ff[2] <= tasp_pkg::POL_MIN_RST;
         hi_ff[2] <= tasp_pkg::POL_MAX_RST;
         step_ff  <= tasp_pkg::STEP_RST;
      end else if (csr_take) begin
         unique case (csr_bus.index)
            tasp_pkg::REG_AZ_MIN:     lo_ff[0] <= csr_bus.data;
            tasp_pkg::REG_AZ_MAX:     hi_ff[0] <= csr_bus.data;
            tasp_pkg::REG_EL_MIN:     lo_ff[1] <= csr_bus.data;
            tasp_pkg::REG_EL_MAX:     hi_ff[1] <= csr_bus.data;
            tasp_pkg::REG_POL_MIN:    lo_ff[2] <= csr_bus.data;
            tasp_pkg::REG_POL_MAX:    hi_ff[2] <= csr_bus.data;
            tasp_pkg::REG_STEP_LIMIT: step_ff  <= csr_bus.data[tasp_pkg::STEP_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // motion state and pipe control
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < tasp_pkg::NUM_AXES; i++) begin
            now_ff[i]  <= '0;
            goal_ff[i] <= '0;
         end
         moving_ff    <= 1'b0;
         running_ff   <= 1'b0;
         calib_ff     <= 1'b0;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            now_ff     <= now_in;
            goal_ff    <= goal_in;
            moving_ff  <= moving_in;
            running_ff <= running_in;
            calib_ff   <= calib_in;
         end
         if (req_bus.ready) begin
            in_valid_ff <= req_bus.valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         cmd_ff    <= req_bus.command;
         mask_ff   <= req_bus.axis_mask;
         val_ff[0] <= req_bus.az_value;
         val_ff[1] <= req_bus.el_value;
         val_ff[2] <= req_bus.pol_value;
      end
      if (advance) begin
         status_ff      <= status_in;
         axerr_ff       <= axerr_in;
         pos_ff         <= now_in;
         moving_out_ff  <= moving_in;
         running_out_ff <= running_in;
         calib_out_ff   <= calib_in;
         arrived_ff     <= arrived_in;
      end
   end

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.status       = status_ff;
   assign rsp_bus.axis_error   = axerr_ff;
   assign rsp_bus.az_position  = pos_ff[0];
   assign rsp_bus.el_position  = pos_ff[1];
   assign rsp_bus.pol_position = pos_ff[2];
   assign rsp_bus.moving       = moving_out_ff;
   assign rsp_bus.running      = running_out_ff;
   assign rsp_bus.calibrated   = calib_out_ff;
   assign rsp_bus.arrived      = arrived_ff;

endmodule

### dv/tasp_motion_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the slew positioner: mirrors its state and checks every result beat.
module tasp_motion_checker
   import tasp_pkg::*;
(
   input  logic clock,
   input  logic reset,
   tasp_req_if  req_mon,
   tasp_rsp_if  rsp_mon,
   tasp_csr_if  csr_mon,
   output int   fail_count,
   output int   beats_seen
);

   typedef struct packed {
      status_type status;
      mask_type   axis_error;
      angle_type  az_position;
      angle_type  el_position;
      angle_type  pol_position;
      logic       moving;
      logic       running;
      logic       calibrated;
      logic       arrived;
   } motion_result_t;

   angle_type      now_pos  [NUM_AXES];
   angle_type      goal_pos [NUM_AXES];
   angle_type      lim_lo   [NUM_AXES];
   angle_type      lim_hi   [NUM_AXES];
   step_type       step_max;
   logic           moving_q;
   logic           running_q;
   logic           calibrated_q;
   motion_result_t expected_q [$];
   int             fails;
   int             seen;
   int             reports;

   // lo wins when the limits are inverted
   function automatic longint clamp_axis(longint v, int ax);
      longint r;
      r = (v < longint'(lim_hi[ax])) ? v : longint'(lim_hi[ax]);
      return (r > longint'(lim_lo[ax])) ? r : longint'(lim_lo[ax]);
   endfunction

   function automatic motion_result_t advance_positioner(cmd_type cmd, mask_type mask,
                                                         angle_type v0, angle_type v1,
                                                         angle_type v2);
      motion_result_t res;
      angle_type      val [NUM_AXES];
      longint         d;
      longint         s;
      longint         stride;
      int             reached;
      res = '0;
      res.status = ST_OK;
      val[0] = v0;
      val[1] = v1;
      val[2] = v2;
      stride = longint'(step_max);
      case (cmd)
         CMD_TICK: begin
            if (moving_q && running_q) begin
               reached = 0;
               for (int i = 0; i < NUM_AXES; i++) begin
                  d = longint'(goal_pos[i]) - longint'(now_pos[i]);
                  if (d > 1 || d < -1) begin
                     s = (d < stride) ? d : stride;
                     if (s < -stride) s = -stride;
                     now_pos[i] = angle_type'(clamp_axis(longint'(now_pos[i]) + s, i));
                  end else begin
                     // within one millidegree: snap onto the goal
                     now_pos[i] = goal_pos[i];
                     reached++;
                  end
               end
               if (reached == NUM_AXES) begin
                  moving_q = 1'b0;
                  res.arrived = 1'b1;
               end
            end
         end
         CMD_SET_TARGET: begin
            if (!running_q) begin
               res.status = ST_NOT_RUNNING;
            end else begin
               for (int i = 0; i < NUM_AXES; i++) begin
                  if (mask[i]) begin
                     if (val[i] < lim_lo[i] || val[i] > lim_hi[i]) begin
                        res.axis_error[i] = 1'b1;
                     end else begin
                        goal_pos[i] = val[i];
                        moving_q = 1'b1;
                     end
                  end
               end
               if (res.axis_error != '0) res.status = ST_OUT_OF_RANGE;
            end
         end
         CMD_START: begin
            if (running_q) res.status = ST_ALREADY_RUN;
            else running_q = 1'b1;
         end
         CMD_STOP: begin
            if (running_q) begin
               running_q = 1'b0;
               res.arrived = moving_q;
               moving_q = 1'b0;
            end else begin
               res.status = ST_ALREADY_STOP;
            end
         end
         CMD_HOME: begin
            for (int i = 0; i < NUM_AXES; i++) begin
               now_pos[i] = angle_type'(clamp_axis(longint'(val[i]), i));
               goal_pos[i] = now_pos[i];
            end
            moving_q = 1'b0;
            calibrated_q = 1'b1;
         end
         default: ;
      endcase
      res.az_position  = now_pos[0];
      res.el_position  = now_pos[1];
      res.pol_position = now_pos[2];
      res.moving       = moving_q;
      res.running      = running_q;
      res.calibrated   = calibrated_q;
      return res;
   endfunction

   task automatic check_field(string fname, longint want, longint got);
      if (want != got) begin
         fails++;
         if (reports < 10) begin
            reports++;
            $display("mismatch on result beat %0d, %s: expected %0d, got %0d",
                     seen, fname, want, got);
         end
      end
   endtask

   always @(posedge clock) begin
      motion_result_t want;
      if (reset) begin
         lim_lo[0]    = AZ_MIN_RST;
         lim_hi[0]    = AZ_MAX_RST;
         lim_lo[1]    = EL_MIN_RST;
         lim_hi[1]    = EL_MAX_RST;
         lim_lo[2]    = POL_MIN_RST;
         lim_hi[2]    = POL_MAX_RST;
         step_max     = STEP_RST;
         for (int i = 0; i < NUM_AXES; i++) begin
            now_pos[i]  = '0;
            goal_pos[i] = '0;
         end
         moving_q     = 1'b0;
         running_q    = 1'b0;
         calibrated_q = 1'b0;
         expected_q.delete();
         fails        = 0;
         seen         = 0;
         reports      = 0;
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               REG_AZ_MIN:     lim_lo[0] = csr_mon.data;
               REG_AZ_MAX:     lim_hi[0] = csr_mon.data;
               REG_EL_MIN:     lim_lo[1] = csr_mon.data;
               REG_EL_MAX:     lim_hi[1] = csr_mon.data;
               REG_POL_MIN:    lim_lo[2] = csr_mon.data;
               REG_POL_MAX:    lim_hi[2] = csr_mon.data;
               REG_STEP_LIMIT: step_max = csr_mon.data[STEP_BITS-1:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            expected_q.push_back(advance_positioner(req_mon.command, req_mon.axis_mask,
                                                    req_mon.az_value, req_mon.el_value,
                                                    req_mon.pol_value));
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen++;
            if (expected_q.size() == 0) begin
               fails++;
               if (reports < 10) begin
                  reports++;
                  $display("result beat %0d arrived with nothing expected", seen);
               end
            end else begin
               want = expected_q.pop_front();
               check_field("status", want.status, rsp_mon.status);
               check_field("axis_error", want.axis_error, rsp_mon.axis_error);
               check_field("az_position", longint'($signed(want.az_position)),
                           longint'($signed(rsp_mon.az_position)));
               check_field("el_position", longint'($signed(want.el_position)),
                           longint'($signed(rsp_mon.el_position)));
               check_field("pol_position", longint'($signed(want.pol_position)),
                           longint'($signed(rsp_mon.pol_position)));
               check_field("moving", want.moving, rsp_mon.moving);
               check_field("running", want.running, rsp_mon.running);
               check_field("calibrated", want.calibrated, rsp_mon.calibrated);
               check_field("arrived", want.arrived, rsp_mon.arrived);
            end
         end
      end
      fail_count <= fails;
      beats_seen <= seen;
   end

endmodule

### dv/tb_three_axis_slew_positioner_unit.sv
`timescale 1ns / 100ps
// Top of the slew positioner testbench: clock, reset, command and register stimulus, verdict.
module tb_three_axis_slew_positioner_unit;
   import tasp_pkg::*;

   localparam int     CYCLE_LIMIT     = 400000;
   localparam int     HOLD_CYCLES     = 240;
   localparam int     PHASES          = 6;
   localparam int     ITEMS_PER_PHASE = 222;
   localparam longint FIELD_MIN       = -360000;
   localparam longint FIELD_MAX       = 360000;
   localparam cmd_type CMD_SPARE_5    = 3'd5;
   localparam cmd_type CMD_SPARE_6    = 3'd6;
   localparam cmd_type CMD_SPARE_7    = 3'd7;

   logic   clock = 1'b0;
   logic   reset = 1'b1;
   int     fail_count;
   int     beats_seen;
   int     items_sent = 0;
   int     directed_items = 0;
   int     cycle_count = 0;
   int     req_idle_pct = 0;
   int     rsp_idle_pct = 0;
   int     hold_left = 0;
   logic   hold_toggle = 1'b0;
   logic   hold_seen = 1'b0;
   bit     offering = 1'b0;
   longint lo_cfg   [NUM_AXES];
   longint hi_cfg   [NUM_AXES];
   longint home_pos [NUM_AXES];
   longint step_cfg;

   always #1 clock = ~clock;

   tasp_req_if req_bus ();
   tasp_rsp_if rsp_bus ();
   tasp_csr_if csr_bus ();

   three_axis_slew_positioner_unit DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   tasp_motion_checker checker_inst (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_bus),
      .rsp_mon    (rsp_bus),
      .csr_mon    (csr_bus),
      .fail_count (fail_count),
      .beats_seen (beats_seen)
   );

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d of %0d results back",
                  cycle_count, beats_seen, items_sent);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // result side: random back-pressure plus an occasional long hold-off
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_toggle != hold_seen) begin
            hold_seen = hold_toggle;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   function automatic angle_type any_angle();
      return angle_type'(longint'($urandom_range(720000)) + FIELD_MIN);
   endfunction

   function automatic angle_type fit_field(longint v);
      if (v < FIELD_MIN) v = FIELD_MIN;
      if (v > FIELD_MAX) v = FIELD_MAX;
      return angle_type'(v);
   endfunction

   function automatic angle_type in_limits(int ax);
      if (lo_cfg[ax] > hi_cfg[ax]) return any_angle();
      return angle_type'(lo_cfg[ax] + longint'($urandom_range(int'(hi_cfg[ax] - lo_cfg[ax]))));
   endfunction

   // targets mostly near the last home, some on or just past the limits
   function automatic angle_type near_goal(int ax, longint spread);
      int r;
      r = $urandom_range(99);
      if (r < 8) return any_angle();
      if (r < 16) begin
         case ($urandom_range(3))
            0: return fit_field(lo_cfg[ax] - 1);
            1: return fit_field(lo_cfg[ax]);
            2: return fit_field(hi_cfg[ax]);
            default: return fit_field(hi_cfg[ax] + 1);
         endcase
      end
      return fit_field(home_pos[ax] + longint'($urandom_range(int'(2 * spread))) - spread);
   endfunction

   task automatic push_item(cmd_type cmd, mask_type mask, angle_type az, angle_type el,
                            angle_type pol);
      if (offering && $urandom_range(99) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         offering = 1'b0;
         do @(posedge clock); while ($urandom_range(99) < req_idle_pct);
      end
      req_bus.valid     <= 1'b1;
      req_bus.command   <= cmd;
      req_bus.axis_mask <= mask;
      req_bus.az_value  <= az;
      req_bus.el_value  <= el;
      req_bus.pol_value <= pol;
      offering = 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      items_sent++;
   endtask

   task automatic drain_results();
      if (offering) begin
         req_bus.valid <= 1'b0;
         offering = 1'b0;
      end
      do @(posedge clock); while (beats_seen != items_sent);
   endtask

   task automatic write_reg(csr_idx_type idx, angle_type value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
   endtask

   task automatic load_config();
      write_reg(REG_AZ_MIN, angle_type'(lo_cfg[0]));
      write_reg(REG_AZ_MAX, angle_type'(hi_cfg[0]));
      write_reg(REG_EL_MIN, angle_type'(lo_cfg[1]));
      write_reg(REG_EL_MAX, angle_type'(hi_cfg[1]));
      write_reg(REG_POL_MIN, angle_type'(lo_cfg[2]));
      write_reg(REG_POL_MAX, angle_type'(hi_cfg[2]));
      write_reg(REG_STEP_LIMIT, angle_type'(step_cfg));
      csr_bus.valid <= 1'b0;
   endtask

   // usually home and start, a few targets each followed by ticks, sometimes a stop
   task automatic run_episode();
      longint    spread;
      angle_type h [NUM_AXES];
      spread = (step_cfg == 0) ? 3 : step_cfg * 10 + 2;
      if (spread > 720000) spread = 720000;
      if ($urandom_range(99) < 70) begin
         for (int ax = 0; ax < NUM_AXES; ax++) begin
            h[ax] = ($urandom_range(9) == 0) ? any_angle() : in_limits(ax);
            home_pos[ax] = longint'(h[ax]);
            if (home_pos[ax] > hi_cfg[ax]) home_pos[ax] = hi_cfg[ax];
            if (home_pos[ax] < lo_cfg[ax]) home_pos[ax] = lo_cfg[ax];
         end
         push_item(CMD_HOME, mask_type'($urandom_range(7)), h[0], h[1], h[2]);
      end
      if ($urandom_range(99) < 85)
         push_item(CMD_START, mask_type'($urandom_range(7)), any_angle(), any_angle(),
                   any_angle());
      repeat ($urandom_range(1, 3)) begin
         push_item(CMD_SET_TARGET,
                   ($urandom_range(9) == 0) ? mask_type'(0) : mask_type'($urandom_range(1, 7)),
                   near_goal(0, spread), near_goal(1, spread), near_goal(2, spread));
         repeat ($urandom_range(1, 14))
            push_item(CMD_TICK, mask_type'($urandom_range(7)), any_angle(), any_angle(),
                      any_angle());
      end
      if ($urandom_range(99) < 30)
         push_item(CMD_STOP, mask_type'($urandom_range(7)), any_angle(), any_angle(),
                   any_angle());
   endtask

   initial begin
      longint a;
      longint b;
      int     phase_goal;
      req_bus.valid     = 1'b0;
      req_bus.command   = CMD_TICK;
      req_bus.axis_mask = '0;
      req_bus.az_value  = '0;
      req_bus.el_value  = '0;
      req_bus.pol_value = '0;
      csr_bus.valid     = 1'b0;
      csr_bus.index     = REG_AZ_MIN;
      csr_bus.data      = '0;
      req_idle_pct      = 8;
      rsp_idle_pct      = 58;
      lo_cfg[0] = longint'(AZ_MIN_RST);
      hi_cfg[0] = longint'(AZ_MAX_RST);
      lo_cfg[1] = longint'(EL_MIN_RST);
      hi_cfg[1] = longint'(EL_MAX_RST);
      lo_cfg[2] = longint'(POL_MIN_RST);
      hi_cfg[2] = longint'(POL_MAX_RST);
      step_cfg  = longint'(STEP_RST);
      for (int ax = 0; ax < NUM_AXES; ax++) home_pos[ax] = 0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed checks under the reset limits
      push_item(CMD_TICK, 3'b000, 0, 0, 0);
      push_item(CMD_SET_TARGET, 3'b111, 1000, 1000, 1000);
      push_item(CMD_STOP, 3'b000, 0, 0, 0);
      push_item(CMD_HOME, 3'b000, -360000, 360000, -360000);
      push_item(CMD_START, 3'b000, 0, 0, 0);
      push_item(CMD_START, 3'b111, 0, 0, 0);
      push_item(CMD_SET_TARGET, 3'b000, 5000, 5000, 5000);
      push_item(CMD_SET_TARGET, 3'b111, 1, 89999, -179999);
      push_item(CMD_TICK, 3'b000, 0, 0, 0);
      push_item(CMD_TICK, 3'b000, 0, 0, 0);
      push_item(CMD_SET_TARGET, 3'b111, -1, 89000, -179000);
      push_item(CMD_TICK, 3'b000, 0, 0, 0);
      push_item(CMD_TICK, 3'b000, 0, 0, 0);
      push_item(CMD_TICK, 3'b000, 0, 0, 0);
      push_item(CMD_SET_TARGET, 3'b001, 360000, 0, 0);
      push_item(CMD_TICK, 3'b000, 0, 0, 0);
      push_item(CMD_STOP, 3'b000, 0, 0, 0);
      push_item(CMD_STOP, 3'b000, 0, 0, 0);
      push_item(CMD_TICK, 3'b111, 360000, 360000, 360000);
      push_item(CMD_SPARE_5, 3'b111, -360000, -360000, -360000);
      push_item(CMD_SPARE_6, 3'b010, 360000, -360000, 360000);
      push_item(CMD_SPARE_7, 3'b101, -360000, 360000, -360000);
      push_item(CMD_HOME, 3'b111, 360000, -90000, 180000);
      push_item(CMD_START, 3'b000, 0, 0, 0);
      push_item(CMD_SET_TARGET, 3'b110, 0, 90001, -180001);
      directed_items = items_sent;
      drain_results();

      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph / 2)
            0: begin
               req_idle_pct = 8;
               rsp_idle_pct <= 58;
            end
            1: begin
               req_idle_pct = 58;
               rsp_idle_pct <= 8;
            end
            default: begin
               req_idle_pct = 0;
               rsp_idle_pct <= 0;
            end
         endcase
         case (ph)
            0: ; // reset values, written back explicitly
            1: begin
               for (int ax = 0; ax < NUM_AXES; ax++) begin
                  lo_cfg[ax] = FIELD_MIN;
                  hi_cfg[ax] = FIELD_MAX;
               end
               step_cfg = 360000;
            end
            2: begin
               // pinned azimuth, inverted elevation, frozen motion
               lo_cfg[0] = 1234;
               hi_cfg[0] = 1234;
               lo_cfg[1] = 50000;
               hi_cfg[1] = -50000;
               lo_cfg[2] = longint'(any_angle());
               hi_cfg[2] = FIELD_MAX;
               step_cfg  = 0;
            end
            default: begin
               for (int ax = 0; ax < NUM_AXES; ax++) begin
                  a = longint'(any_angle());
                  b = longint'(any_angle());
                  if ((a <= b) == ($urandom_range(99) < 85)) begin
                     lo_cfg[ax] = a;
                     hi_cfg[ax] = b;
                  end else begin
                     lo_cfg[ax] = b;
                     hi_cfg[ax] = a;
                  end
               end
               step_cfg = (ph == 3) ? 1 : (ph == 4) ? 2 : longint'($urandom_range(3, 20000));
            end
         endcase
         load_config();
         if (ph == 4) hold_toggle <= ~hold_toggle;
         phase_goal = items_sent + ITEMS_PER_PHASE;
         while (items_sent < phase_goal) begin
            if ($urandom_range(99) < 82) begin
               run_episode();
            end else begin
               repeat ($urandom_range(1, 6))
                  push_item(cmd_type'($urandom_range(7)), mask_type'($urandom_range(7)),
                            any_angle(), any_angle(), any_angle());
            end
         end
         drain_results();
      end

      repeat (4) @(posedge clock);
      $display("covered %0d directed and %0d random commands over %0d register settings",
               directed_items, items_sent - directed_items, PHASES);
      $display("%0d result beats checked, %0d field mismatches", beats_seen, fail_count);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

### sim.f
rtl/core/tasp_pkg.sv
rtl/core/tasp_ifs.sv
rtl/core/three_axis_slew_positioner_unit.sv
dv/tasp_motion_checker.sv
dv/tb_three_axis_slew_positioner_unit.sv
